// ===== rtl/tbrl_pkg.sv =====
package tbrl_pkg;

  localparam int RATE_W       = 20;
  localparam int ELAPSED_W    = 24;
  localparam int ELAPSED_BITS = 24;
  localparam int LEVEL_W      = 41;
  localparam int WAIT_W       = 17;

  // Product of the elapsed time and the rate, and the bucket sum before saturation.
  localparam int PROD_W = ELAPSED_BITS + RATE_W;
  localparam int SUM_W  = ((PROD_W > LEVEL_W) ? PROD_W : LEVEL_W) + 1;

  // A refused request has a level below one token, so the numerator fits 20 bits.
  localparam int DIV_BITS = 20;
  localparam int STEP_MAX = (ELAPSED_BITS > DIV_BITS) ? ELAPSED_BITS : DIV_BITS;
  localparam int CNT_W    = $clog2(STEP_MAX);

  localparam logic [LEVEL_W-1:0]  TOKEN        = LEVEL_W'(1000000);
  localparam logic [LEVEL_W-1:0]  CAP_PER_RATE = LEVEL_W'(2000000);
  localparam logic [DIV_BITS-1:0] WAIT_MIN     = DIV_BITS'(1000);
  localparam logic [DIV_BITS-1:0] WAIT_MAX     = DIV_BITS'(100000);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_SAT,
    ST_TAKE,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic [DIV_BITS-1:0] num;
    logic [RATE_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [DIV_BITS-1:0] quot;
  } div_stat_t;

endpackage

// ===== rtl/tbrl_ifs.sv =====
interface tbrl_req_if import tbrl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 cmd;
  logic [ELAPSED_W-1:0] elapsed_us;
  modport source(output valid, cmd, elapsed_us, input ready);
  modport sink(input valid, cmd, elapsed_us, output ready);
endinterface

interface tbrl_rsp_if import tbrl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              granted;
  logic [WAIT_W-1:0] wait_us;
  modport source(output valid, granted, wait_us, input ready);
  modport sink(input valid, granted, wait_us, output ready);
endinterface

interface tbrl_cfg_if import tbrl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] rate_per_second;
  modport source(output valid, rate_per_second, input ready);
  modport sink(input valid, rate_per_second, output ready);
endinterface

// ===== rtl/token_bucket_rate_limiter_unit.sv =====
// Channel  Dir  Payload                              Accepted when
// req      in   cmd, elapsed_us[23:0]                req.valid && req.ready
// rsp      out  granted, wait_us[16:0]               rsp.valid && rsp.ready
// cfg      in   rate_per_second[19:0]                cfg.valid && cfg.ready
//
// A time-only item or a granted request runs the bit-serial multiply of time by rate,
// then the add, saturate and take steps, from acceptance to a loaded result.
// A refused request adds the serial divider before its result is loaded.
// rst is synchronous and active high; it clears the rate, the bucket and all control.
// A result waits in the output register while rsp stalls; the next item is accepted
// meanwhile and only its own result waits for the register to drain.
module token_bucket_rate_limiter_unit import tbrl_pkg::*; (
  input logic         clk,
  input logic         rst,
  tbrl_req_if.sink    req,
  tbrl_rsp_if.source  rsp,
  tbrl_cfg_if.sink    cfg
);

  state_t state;
  state_t state_next;

  // Configuration and bucket state. The cap is kept alongside the rate so that
  // the saturation compare never sits behind a multiplier.
  logic [RATE_W-1:0]  rate;
  logic [LEVEL_W-1:0] cap;
  logic [LEVEL_W-1:0] level;

  // Item being worked on.
  logic                    cmd;
  logic [CNT_W-1:0]        cnt;
  logic [RATE_W-1:0]       prod_hi;
  logic [ELAPSED_BITS-1:0] prod_lo;
  logic [SUM_W-1:0]        sum;

  // Result waiting for the output register, and the output register itself.
  logic              res_granted;
  logic [WAIT_W-1:0] res_wait;
  logic              out_valid;
  logic              out_granted;
  logic [WAIT_W-1:0] out_wait;

  // Control decoded from the state.
  logic accept;
  logic load_out;
  logic div_start;

  div_req_t  div_req;
  div_stat_t div_stat;

  logic [RATE_W:0]      mul_add;
  logic [PROD_W-1:0]    prod;
  logic                 take_ok;
  logic [DIV_BITS-1:0]  clamped;

  // One bit of the elapsed time per cycle: add the rate to the upper half when
  // the low bit is set, then shift the whole product right by one.
  assign mul_add = {1'b0, prod_hi} + (prod_lo[0] ? {1'b0, rate} : '0);
  assign prod    = {prod_hi, prod_lo};
  assign take_ok = (level >= TOKEN);

  always_comb begin
    if (div_stat.quot < WAIT_MIN) begin
      clamped = WAIT_MIN;
    end else if (div_stat.quot > WAIT_MAX) begin
      clamped = WAIT_MAX;
    end else begin
      clamped = div_stat.quot;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (req.valid) state_next = ST_MUL;
      ST_MUL:  if (cnt == '0) state_next = ST_ADD;
      ST_ADD:  state_next = ST_SAT;
      ST_SAT:  state_next = ST_TAKE;
      ST_TAKE: begin
        if (cmd && rate != '0 && !take_ok) begin
          state_next = ST_DIV;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_DIV:  if (div_stat.done) state_next = ST_OUT;
      ST_OUT:  if (!out_valid || rsp.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    req.ready = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      ST_IDLE: req.ready = 1'b1;
      ST_TAKE: div_start = cmd && rate != '0 && !take_ok;
      ST_OUT:  load_out  = !out_valid || rsp.ready;
      default: ;
    endcase
  end

  assign accept    = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  assign div_req.start = div_start;
  assign div_req.num   = DIV_BITS'(TOKEN - level);
  assign div_req.den   = rate;

  tbrl_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .stat (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rate      <= '0;
      cap       <= '0;
      level     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg.valid && cfg.ready) begin
        // Writing the rate refills the bucket to twice the rate in whole tokens.
        rate  <= cfg.rate_per_second;
        cap   <= LEVEL_W'(cfg.rate_per_second) * CAP_PER_RATE;
        level <= LEVEL_W'(cfg.rate_per_second) * CAP_PER_RATE;
      end else if (state == ST_SAT) begin
        level <= (sum > SUM_W'(cap)) ? cap : LEVEL_W'(sum);
      end else if (state == ST_TAKE && cmd && rate != '0 && take_ok) begin
        level <= level - TOKEN;
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd     <= req.cmd;
      cnt     <= CNT_W'(ELAPSED_BITS - 1);
      prod_hi <= '0;
      prod_lo <= ELAPSED_BITS'(req.elapsed_us);
    end
    if (state == ST_MUL) begin
      prod_hi <= mul_add[RATE_W:1];
      prod_lo <= {mul_add[0], prod_lo[ELAPSED_BITS-1:1]};
      cnt     <= cnt - 1'b1;
    end
    if (state == ST_ADD) begin
      sum <= SUM_W'(level) + SUM_W'(prod);
    end
    if (state == ST_TAKE) begin
      // A time-only item, a disabled limiter and a granted request end here.
      res_granted <= cmd && (rate == '0 || take_ok);
      res_wait    <= '0;
    end
    if (state == ST_DIV && div_stat.done) begin
      res_wait <= WAIT_W'(clamped);
    end
    if (load_out) begin
      out_granted <= res_granted;
      out_wait    <= res_wait;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.granted = out_granted;
  assign rsp.wait_us = out_wait;

  // The bucket never holds more than its cap.
  assert property (@(posedge clk) disable iff (rst) level <= cap)
    else $error("bucket level above cap");

  // The divider finishes only while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst) div_stat.done |-> state == ST_DIV)
    else $error("divider done outside the divide state");

  // An accepted item always starts the serial multiply.
  assert property (@(posedge clk) disable iff (rst) accept |=> state == ST_MUL)
    else $error("accepted item did not start multiply");

  // A granted result carries no wait hint.
  assert property (@(posedge clk) disable iff (rst) out_valid && out_granted |-> out_wait == '0)
    else $error("granted result with nonzero wait");

  // A nonzero wait hint lies within the clamp range.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_wait != '0 |->
      out_wait >= WAIT_W'(WAIT_MIN) && out_wait <= WAIT_W'(WAIT_MAX))
    else $error("wait hint outside clamp range");

endmodule

// ===== rtl/tbrl_div.sv =====
// Restoring divider, one quotient bit per cycle.
module tbrl_div import tbrl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  div_req_t  req,
  output div_stat_t stat
);

  logic [DIV_BITS-1:0] quot;
  logic [RATE_W-1:0]   rem;
  logic [CNT_W-1:0]    cnt;
  logic                busy;
  logic                done;
  logic [RATE_W:0]     trial;

  assign trial = {rem, quot[DIV_BITS-1]} - {1'b0, req.den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_BITS - 1);
        rem  <= '0;
        quot <= req.num;
      end else if (busy) begin
        if (!trial[RATE_W]) begin
          rem  <= trial[RATE_W-1:0];
          quot <= {quot[DIV_BITS-2:0], 1'b1};
        end else begin
          rem  <= {rem[RATE_W-2:0], quot[DIV_BITS-1]};
          quot <= {quot[DIV_BITS-2:0], 1'b0};
        end
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign stat.done = done;
  assign stat.quot = quot;

endmodule

// ===== test/token_bucket_rate_limiter_unit_tb.sv =====
module token_bucket_rate_limiter_unit_tb;
  import tbrl_pkg::*;

  // Request codes carried on req.cmd.
  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_ACQUIRE = 1'b1;

  // One token is a million millionths; the bucket holds at most two seconds of refill.
  localparam longint unsigned TOKEN_MICRO    = 64'd1000000;
  localparam longint unsigned CAP_PER_RATE_U = 64'd2000000;
  localparam longint unsigned HINT_MIN       = 64'd1000;
  localparam longint unsigned HINT_MAX       = 64'd100000;

  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int PHASES         = 13;
  localparam int PHASE_ITEMS    = 50;

  typedef struct packed {
    logic              granted;
    logic [WAIT_W-1:0] wait_us;
  } verdict_t;

  // A row of the directed script: either a rate write or an item, with an
  // optional typed-in result that replaces the predicted one.
  typedef struct packed {
    bit                   set_rate;
    logic [RATE_W-1:0]    rate;
    logic                 cmd;
    logic [ELAPSED_W-1:0] elapsed;
    bit                   typed;
    verdict_t             want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst;

  tbrl_req_if req_ch();
  tbrl_rsp_if rsp_ch();
  tbrl_cfg_if cfg_ch();

  token_bucket_rate_limiter_unit uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Our own copy of the limiter: the configured rate and the fill level in
  // millionths of a token.
  longint unsigned bucket_rate;
  longint unsigned bucket_fill;

  verdict_t    pending_verdicts[$];
  script_row_t script[$];
  int          mismatch_count = 0;

  // The last phases run with no idling on either side; hold_rsp asks the
  // response side for one long stall.
  bit calm     = 1'b0;
  bit hold_rsp = 1'b0;

  // Advance the bucket by one item and work out the grant or the retry hint.
  function automatic verdict_t bucket_step(input logic c, input logic [ELAPSED_W-1:0] el);
    longint unsigned cap;
    longint unsigned sum;
    longint unsigned hint;
    longint unsigned dt;
    verdict_t v;
    dt  = 64'(el) & ((64'd1 << ELAPSED_BITS) - 64'd1);
    cap = bucket_rate * CAP_PER_RATE_U;
    sum = bucket_fill + dt * bucket_rate;
    bucket_fill = (sum > cap) ? cap : sum;
    v = '0;
    if (c == CMD_ACQUIRE) begin
      if (bucket_rate == 0) begin
        v.granted = 1'b1;
      end else if (bucket_fill >= TOKEN_MICRO) begin
        bucket_fill = bucket_fill - TOKEN_MICRO;
        v.granted = 1'b1;
      end else begin
        hint = (TOKEN_MICRO - bucket_fill) / bucket_rate;
        if (hint < HINT_MIN) hint = HINT_MIN;
        if (hint > HINT_MAX) hint = HINT_MAX;
        v.wait_us = WAIT_W'(hint);
      end
    end
    return v;
  endfunction

  // Rates lean toward small values so the bucket drains and refusals happen.
  function automatic logic [RATE_W-1:0] pick_rate();
    int unsigned kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0: return '0;
      1: return '1;
      2: return RATE_W'($urandom_range(1, (1 << RATE_W) - 1));
      default: return RATE_W'($urandom_range(1, 16));
    endcase
  endfunction

  // Elapsed times are scaled to the time one token takes at the current rate,
  // with a share of zeros, maximum values and fully random words.
  function automatic logic [ELAPSED_W-1:0] pick_elapsed();
    int unsigned kind;
    longint unsigned period;
    longint unsigned el;
    kind = $urandom_range(0, 9);
    period = (bucket_rate == 0) ? 64'd1000 : TOKEN_MICRO / bucket_rate;
    case (kind)
      0: el = 0;
      1: el = 64'hFF_FFFF;
      2: el = 64'($urandom);
      3, 4, 5: el = 64'($urandom_range(0, int'(period / 2)));
      default: el = 64'($urandom_range(0, int'(2 * period)));
    endcase
    if (el > 64'hFF_FFFF && kind != 2) el = 64'hFF_FFFF;
    return ELAPSED_W'(el);
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic add_rate(input logic [RATE_W-1:0] r);
    script_row_t row;
    row = '0;
    row.set_rate = 1'b1;
    row.rate = r;
    script.push_back(row);
  endtask

  task automatic add_item(input logic c, input logic [ELAPSED_W-1:0] el, input bit typed,
                          input logic g, input logic [WAIT_W-1:0] w);
    script_row_t row;
    row = '0;
    row.cmd = c;
    row.elapsed = el;
    row.typed = typed;
    row.want.granted = g;
    row.want.wait_us = w;
    script.push_back(row);
  endtask

  // Offer one item, possibly after a short idle burst, and wait until it is
  // taken. The expected result is queued at the edge that accepts the item.
  // Valid is left high so that back-to-back items need no extra assignment.
  task automatic offer_item(input logic c, input logic [ELAPSED_W-1:0] el, input bit typed,
                            input verdict_t want);
    verdict_t v;
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.cmd        <= c;
    req_ch.elapsed_us <= el;
    do @(posedge clk); while (!req_ch.ready);
    v = bucket_step(c, el);
    if (typed) v = want;
    pending_verdicts.push_back(v);
  endtask

  // The rate is only written with the block idle: the request channel is
  // closed first and every outstanding result has to come back.
  task automatic set_rate(input logic [RATE_W-1:0] r);
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid           <= 1'b1;
    cfg_ch.rate_per_second <= r;
    do @(posedge clk); while (!cfg_ch.ready);
    bucket_rate = 64'(r);
    bucket_fill = bucket_rate * CAP_PER_RATE_U;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Response side: ready drops in short random bursts, and once for a long
  // stretch so the block backs up and stalls its request channel.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rsp) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_rsp = 1'b0;
        rsp_ch.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Every accepted result is compared with the oldest expectation.
  always @(posedge clk) begin : check_results
    verdict_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("unexpected result granted=%0d wait_us=%0d",
                                  rsp_ch.granted, rsp_ch.wait_us));
      end else begin
        want = pending_verdicts.pop_front();
        if (rsp_ch.granted !== want.granted)
          report_mismatch($sformatf("granted %0d, expected %0d",
                                    rsp_ch.granted, want.granted));
        if (rsp_ch.wait_us !== want.wait_us)
          report_mismatch($sformatf("wait_us %0d, expected %0d",
                                    rsp_ch.wait_us, want.wait_us));
      end
    end
  end

  // The watchdog counts cycles in which no channel moves anything.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("token_bucket_rate_limiter_unit_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    script_row_t row;
    rst                    = 1'b1;
    req_ch.valid           = 1'b0;
    req_ch.cmd             = CMD_TICK;
    req_ch.elapsed_us      = '0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.rate_per_second = '0;
    bucket_rate = 0;
    bucket_fill = 0;

    // Out of reset the rate is zero, so limiting is off and every request is
    // granted no matter how much time passes.
    add_item(CMD_ACQUIRE, 24'd0,        1, 1'b1, 17'd0);
    add_item(CMD_TICK,    24'hFF_FFFF,  1, 1'b0, 17'd0);
    add_item(CMD_ACQUIRE, 24'hFF_FFFF,  1, 1'b1, 17'd0);
    // At one token per second the refilled bucket holds two tokens. Once it is
    // empty the hint walks through the upper clamp, its exact edge, the lower
    // clamp and its edge, until exactly one token has built up again.
    add_rate(20'd1);
    add_item(CMD_ACQUIRE, 24'd0,        1, 1'b1, 17'd0);
    add_item(CMD_ACQUIRE, 24'd0,        1, 1'b1, 17'd0);
    add_item(CMD_ACQUIRE, 24'd0,        1, 1'b0, 17'd100000);
    add_item(CMD_ACQUIRE, 24'd900000,   1, 1'b0, 17'd100000);
    add_item(CMD_ACQUIRE, 24'd1,        0, 1'b0, 17'd0);
    add_item(CMD_ACQUIRE, 24'd98999,    1, 1'b0, 17'd1000);
    add_item(CMD_ACQUIRE, 24'd1,        1, 1'b0, 17'd1000);
    add_item(CMD_ACQUIRE, 24'd999,      1, 1'b1, 17'd0);
    // A huge time step must saturate at two tokens rather than wrap.
    add_item(CMD_TICK,    24'hFF_FFFF,  1, 1'b0, 17'd0);
    add_item(CMD_ACQUIRE, 24'd0,        1, 1'b1, 17'd0);
    add_item(CMD_ACQUIRE, 24'd0,        1, 1'b1, 17'd0);
    add_item(CMD_ACQUIRE, 24'd0,        1, 1'b0, 17'd100000);
    // The largest rate with the largest time step stays at the cap.
    add_rate(20'hF_FFFF);
    add_item(CMD_ACQUIRE, 24'hFF_FFFF,  1, 1'b1, 17'd0);
    add_item(CMD_TICK,    24'd0,        1, 1'b0, 17'd0);
    add_rate(20'd0);
    add_item(CMD_ACQUIRE, 24'd5,        1, 1'b1, 17'd0);
    add_rate(20'd7);
    add_item(CMD_TICK,    24'hAA_AAAA,  0, 1'b0, 17'd0);
    add_item(CMD_ACQUIRE, 24'h55_5555,  0, 1'b0, 17'd0);

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      row = script[i];
      if (row.set_rate) set_rate(row.rate);
      else offer_item(row.cmd, row.elapsed, row.typed, row.want);
    end

    // Random phases, each under a freshly written rate. The long response
    // stall falls early in one phase; the last two phases run without idling.
    for (int ph = 0; ph < PHASES; ph++) begin
      set_rate(pick_rate());
      calm = (ph >= PHASES - 2);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 3 && k == 5) hold_rsp = 1'b1;
        offer_item(($urandom_range(0, 4) != 0) ? CMD_ACQUIRE : CMD_TICK, pick_elapsed(),
                   1'b0, '0);
      end
    end

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("token_bucket_rate_limiter_unit_tb: done, clean");
    end else begin
      $display("token_bucket_rate_limiter_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
